FILE: design/rgb_status_led_sequencer_core_defines.svh
// assertion macros for the rgb status pixel sequencer
`ifndef RGB_STATUS_LED_SEQUENCER_CORE_DEFINES_SVH
`define RGB_STATUS_LED_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RGBSL_ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("rgbsl assertion failed");

// next-cycle implication, checked outside reset
`define RGBSL_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("rgbsl assertion failed");

`endif

FILE: design/rgbsl_pkg.sv
// shared types and constants for the rgb status pixel sequencer
`default_nettype none

package rgbsl_pkg;

   // elapsed tick counter width
   localparam int TICK_BITS = 10;
   // compare width, wide enough for the counter and the period register
   localparam int CMP_BITS  = (TICK_BITS > 10) ? TICK_BITS : 10;

   localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

   // request types
   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_COLOUR = 2'd1;
   localparam logic [1:0] REQ_MODE   = 2'd2;

   // mode numbers
   localparam logic [2:0] MODE_STATIC_GREEN = 3'd0;
   localparam logic [2:0] MODE_FAST_GREEN   = 3'd1;
   localparam logic [2:0] MODE_RED_BLINK    = 3'd2;
   localparam logic [2:0] MODE_DONE_BLINK   = 3'd3;
   localparam logic [2:0] MODE_WARN_BLINK   = 3'd4;
   localparam logic [2:0] MODE_AMBER        = 3'd5;

   // colours, red in the top byte
   localparam logic [23:0] COL_BLACK  = 24'h000000;
   localparam logic [23:0] COL_GREEN  = 24'h00FF00;
   localparam logic [23:0] COL_RED    = 24'hFF0000;
   localparam logic [23:0] COL_ORANGE = 24'hFFA500;
   localparam logic [23:0] COL_AMBER  = 24'hFF7F00;

   // intervals in ticks
   localparam int DONE_INTERVAL = 200;
   localparam int WARN_INTERVAL = 300;
   localparam logic [9:0] PERIOD_FAST = 10'd50;
   localparam logic [9:0] PERIOD_SLOW = 10'd500;
   localparam logic [9:0] PERIOD_WARN = 10'd300;
   localparam logic [2:0] DONE_PHASES = 3'd6;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [2:0] mode_in;
   } req_item_type;

   typedef struct packed {
      logic [7:0] shown_red;
      logic [7:0] shown_green;
      logic [7:0] shown_blue;
      logic [2:0] active_mode;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0]           mode;
      logic [23:0]          base_colour;
      logic [9:0]           blink_period;
      logic                 blink_on;
      logic                 blink_phase;
      logic                 done_phase;
      logic [2:0]           done_count;
      logic [TICK_BITS-1:0] elapsed;
      logic [23:0]          display_colour;
   } state_type;

endpackage

`default_nettype wire

FILE: design/rgbsl_step.sv
// next-state logic of the sequencer for one item
`default_nettype none

module rgbsl_step (
   input  wire rgbsl_pkg::state_type    cur,
   input  wire rgbsl_pkg::req_item_type item,
   input  wire                          led_enable,
   output rgbsl_pkg::state_type         nxt
);

   logic [rgbsl_pkg::TICK_BITS-1:0] elapsed_inc;
   logic [rgbsl_pkg::CMP_BITS-1:0]  elapsed_ext;
   logic [rgbsl_pkg::CMP_BITS-1:0]  period_ext;
   logic                            done_due;
   logic                            warn_due;
   logic                            blink_due;
   logic                            is_blinking;
   logic [2:0]                      count_inc;

   // saturating tick count and the interval compares
   always_comb begin
      elapsed_inc = (cur.elapsed == rgbsl_pkg::TICK_MAX) ? cur.elapsed
                    : cur.elapsed + {{(rgbsl_pkg::TICK_BITS-1){1'b0}}, 1'b1};
      elapsed_ext = rgbsl_pkg::CMP_BITS'(elapsed_inc);
      period_ext  = rgbsl_pkg::CMP_BITS'(cur.blink_period);
      done_due    = elapsed_ext >= rgbsl_pkg::CMP_BITS'(rgbsl_pkg::DONE_INTERVAL);
      warn_due    = elapsed_ext >= rgbsl_pkg::CMP_BITS'(rgbsl_pkg::WARN_INTERVAL);
      blink_due   = elapsed_ext >= period_ext;
      is_blinking = cur.blink_on || (cur.mode == rgbsl_pkg::MODE_FAST_GREEN)
                    || (cur.mode == rgbsl_pkg::MODE_RED_BLINK);
      count_inc   = cur.done_count + 3'd1;
   end

   // state update per request type
   always_comb begin
      nxt = cur;
      case (item.req_type)
         rgbsl_pkg::REQ_TICK: begin
            nxt.elapsed = elapsed_inc;
            if (!led_enable) begin
               nxt.display_colour = rgbsl_pkg::COL_BLACK;
            end else if (cur.mode == rgbsl_pkg::MODE_DONE_BLINK) begin
               if (done_due) begin
                  nxt.elapsed        = '0;
                  nxt.done_phase     = ~cur.done_phase;
                  nxt.display_colour = cur.done_phase ? rgbsl_pkg::COL_BLACK
                                       : rgbsl_pkg::COL_ORANGE;
                  // end of an on phase: count it, finish after the last one
                  if (cur.done_phase) begin
                     nxt.done_count = count_inc;
                     if (count_inc >= rgbsl_pkg::DONE_PHASES) begin
                        nxt.mode           = rgbsl_pkg::MODE_STATIC_GREEN;
                        nxt.done_count     = 3'd0;
                        nxt.base_colour    = rgbsl_pkg::COL_GREEN;
                        nxt.display_colour = rgbsl_pkg::COL_GREEN;
                        nxt.blink_on       = 1'b0;
                     end
                  end
               end
            end else if (cur.mode == rgbsl_pkg::MODE_WARN_BLINK) begin
               if (warn_due) begin
                  nxt.elapsed        = '0;
                  nxt.blink_phase    = ~cur.blink_phase;
                  nxt.display_colour = cur.blink_phase ? rgbsl_pkg::COL_BLACK
                                       : rgbsl_pkg::COL_ORANGE;
               end
            end else if (is_blinking) begin
               if (blink_due) begin
                  nxt.elapsed        = '0;
                  nxt.blink_phase    = ~cur.blink_phase;
                  nxt.display_colour = cur.blink_phase ? rgbsl_pkg::COL_BLACK
                                       : cur.base_colour;
               end
            end else begin
               nxt.display_colour = cur.base_colour;
            end
         end
         rgbsl_pkg::REQ_COLOUR: begin
            if (led_enable) begin
               nxt.base_colour    = {item.red_in, item.green_in, item.blue_in};
               nxt.display_colour = {item.red_in, item.green_in, item.blue_in};
               nxt.mode           = rgbsl_pkg::MODE_STATIC_GREEN;
               nxt.blink_on       = 1'b0;
               nxt.done_count     = 3'd0;
            end
         end
         rgbsl_pkg::REQ_MODE: begin
            // modes six and seven are ignored
            if (item.mode_in <= rgbsl_pkg::MODE_AMBER) begin
               nxt.mode        = item.mode_in;
               nxt.elapsed     = '0;
               nxt.blink_phase = 1'b0;
               nxt.done_count  = 3'd0;
               case (item.mode_in)
                  rgbsl_pkg::MODE_STATIC_GREEN: begin
                     nxt.base_colour  = rgbsl_pkg::COL_GREEN;
                     nxt.blink_period = rgbsl_pkg::PERIOD_SLOW;
                     nxt.blink_on     = 1'b0;
                  end
                  rgbsl_pkg::MODE_FAST_GREEN: begin
                     nxt.base_colour  = rgbsl_pkg::COL_GREEN;
                     nxt.blink_period = rgbsl_pkg::PERIOD_FAST;
                     nxt.blink_on     = 1'b1;
                  end
                  rgbsl_pkg::MODE_RED_BLINK: begin
                     nxt.base_colour  = rgbsl_pkg::COL_RED;
                     nxt.blink_period = rgbsl_pkg::PERIOD_SLOW;
                     nxt.blink_on     = 1'b1;
                  end
                  rgbsl_pkg::MODE_DONE_BLINK: begin
                     nxt.done_phase = 1'b1;
                  end
                  rgbsl_pkg::MODE_WARN_BLINK: begin
                     nxt.base_colour  = rgbsl_pkg::COL_ORANGE;
                     nxt.blink_period = rgbsl_pkg::PERIOD_WARN;
                     nxt.blink_on     = 1'b1;
                  end
                  default: begin
                     nxt.base_colour  = rgbsl_pkg::COL_AMBER;
                     nxt.blink_period = rgbsl_pkg::PERIOD_SLOW;
                     nxt.blink_on     = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/rgb_status_led_sequencer_core.sv
// An accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless the result stalls; rgbsl_step runs once per item.
// An input register and a result register part the two channels, so a stalled
// result still lets one more item in.
// Reset (synchronous, active high) clears all state to zero and black, and sets led_enable.
`default_nettype none

`include "rgb_status_led_sequencer_core_defines.svh"

module rgb_status_led_sequencer_core (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire rgbsl_pkg::req_item_type req_item,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output rgbsl_pkg::rsp_item_type      rsp_item,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire                          csr_led_enable
);

   logic                    in_valid_ff;
   rgbsl_pkg::req_item_type in_item_ff;
   logic                    rsp_valid_ff;
   rgbsl_pkg::rsp_item_type rsp_item_ff;
   logic                    led_enable_ff;
   rgbsl_pkg::state_type    state_ff;
   rgbsl_pkg::state_type    state_in;
   logic                    advance;

   // handshake control
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // next state for the item in the input register
   rgbsl_step u_step (
      .cur        (state_ff),
      .item       (in_item_ff),
      .led_enable (led_enable_ff),
      .nxt        (state_in)
   );

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         led_enable_ff <= 1'b1;
      end else if (csr_valid) begin
         led_enable_ff <= csr_led_enable;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_item;
      end
   end

   // sequencer state, stepped once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff.shown_red   <= state_in.display_colour[23:16];
         rsp_item_ff.shown_green <= state_in.display_colour[15:8];
         rsp_item_ff.shown_blue  <= state_in.display_colour[7:0];
         rsp_item_ff.active_mode <= state_in.mode;
      end
   end

   // checks
   `RGBSL_ASSERT_NEXT(a_advance_gives_result, clock, reset, advance, rsp_valid)
   `RGBSL_ASSERT_NEXT(a_disabled_tick_black, clock, reset,
      advance && !led_enable_ff && (in_item_ff.req_type == rgbsl_pkg::REQ_TICK),
      (rsp_item.shown_red == 8'd0) && (rsp_item.shown_green == 8'd0)
      && (rsp_item.shown_blue == 8'd0))
   `RGBSL_ASSERT_IMPLIES(a_mode_in_range, clock, reset, 1'b1,
      state_ff.mode <= rgbsl_pkg::MODE_AMBER)
   `RGBSL_ASSERT_IMPLIES(a_stalled_holds_input, clock, reset,
      in_valid_ff && rsp_valid_ff && !rsp_ready, !req_ready)

endmodule

`default_nettype wire
